// ===== rtl/neighbor_table_with_aging_macros.svh =====
// ----------------------------------------------------------------------------
// Neighbor table assertion macros
// Shared concurrent assertion forms, clocked on clk and gated by rst_n.
// ----------------------------------------------------------------------------
`ifndef NEIGHBOR_TABLE_WITH_AGING_MACROS_SVH
`define NEIGHBOR_TABLE_WITH_AGING_MACROS_SVH

// Same-cycle implication.
`define NTAGE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define NTAGE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ntage_pkg.sv =====
// ----------------------------------------------------------------------------
// ntage_pkg
// Shared types and constants for the neighbor table with aging.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ntage_pkg;

    localparam int TABLE_DEPTH_DEF = 4;
    localparam logic [7:0] AGE_LIMIT_RESET = 8'd64;

    // Result status codes
    localparam logic [1:0] ST_UPDATED  = 2'd0;
    localparam logic [1:0] ST_INSERTED = 2'd1;
    localparam logic [1:0] ST_DROPPED  = 2'd2;
    localparam logic [1:0] ST_PURGED   = 2'd3;

    // Item function codes
    localparam logic FUNC_RECEIVE = 1'b0;
    localparam logic FUNC_PURGE   = 1'b1;

    typedef struct packed {
        logic [7:0] id;
        logic [7:0] distance;
        logic [7:0] stamp;
    } entry_t;

    // Per-cycle command broadcast to every cell
    typedef struct packed {
        logic rotate;   // pop head, shift valid prefix down, feed into last valid slot
        logic append;   // load feed into first free slot
    } cell_ctl_t;

endpackage

// ===== rtl/ntage_cell.sv =====
// ----------------------------------------------------------------------------
// ntage_cell
// One table slot; loads from its right neighbor or the feed word on command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ntage_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 3
) (
    input  logic                clk,
    input  ntage_pkg::cell_ctl_t ctl,
    input  logic [CNT_W-1:0]    count,
    input  ntage_pkg::entry_t   right,
    input  ntage_pkg::entry_t   feed,
    output ntage_pkg::entry_t   entry
);

    localparam logic [CNT_W-1:0] IDX_C  = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] IDX1_C = CNT_W'(IDX + 1);

    ntage_pkg::entry_t entry_reg;
    ntage_pkg::entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.rotate)
        begin
            if (IDX1_C < count)
                entry_next = right;
            else if (IDX1_C == count)
                entry_next = feed;
        end
        else if (ctl.append && (IDX_C == count))
        begin
            entry_next = feed;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== rtl/neighbor_table_with_aging.sv =====
// ----------------------------------------------------------------------------
// neighbor_table_with_aging
// Neighbor table held in a row of slot cells, walked as a rotating queue.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | word
//  --------+-----------+-----------------------+----------------------------------
//  item    | in        | start & !busy         | func, sender_id, measured_distance,
//          |           |                       | now_tick
//  result  | out       | done (one cycle)      | entry_count, status, removed_count
//  config  | in        | cfg_valid & cfg_ready | cfg_data = age_limit
//
//  done follows a walk that pops each stored entry in turn from the head of the
//  cell row, then a decision step, plus an append step on insert. busy drops in
//  the cycle done is shown, so the next item may start then. Reset clears the
//  entry count and restores age_limit; slot contents are not cleared. Results
//  cannot be stalled; done lasts exactly one cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "neighbor_table_with_aging_macros.svh"

module neighbor_table_with_aging #(
    parameter int TABLE_DEPTH = ntage_pkg::TABLE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    // item
    input  logic       start,
    output logic       busy,
    input  logic       func,
    input  logic [7:0] sender_id,
    input  logic [7:0] measured_distance,
    input  logic [7:0] now_tick,
    // result
    output logic       done,
    output logic [2:0] entry_count,
    output logic [1:0] status,
    output logic [2:0] removed_count,
    // config
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

    // Sequencer states
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_WALK   = 2'd1;
    localparam logic [1:0] S_APPEND = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] steps_reg, steps_next;
    logic [CNT_W-1:0] removed_reg, removed_next;
    logic             hit_reg, hit_next;
    logic [7:0]       age_limit_reg;

    // latched item
    logic             func_reg;
    logic [7:0]       id_reg, dist_reg, now_reg;

    // result registers
    logic             done_reg, done_next;
    logic [2:0]       ecount_reg, ecount_next;
    logic [1:0]       status_reg, status_next;
    logic [2:0]       rcount_reg, rcount_next;

    ntage_pkg::cell_ctl_t ctl;
    ntage_pkg::entry_t    feed;
    ntage_pkg::entry_t    head;
    ntage_pkg::entry_t    fresh;
    ntage_pkg::entry_t    cell_q [TABLE_DEPTH];

    logic       accept;
    logic       is_hit;
    logic       is_old;
    logic [7:0] age;

    assign accept    = start && (state_reg == S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    // ---- cell row: cell i takes cell i+1, the last one takes the feed ----
    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++)
        begin : g_cell
            ntage_pkg::entry_t right_w;
            if (gi == TABLE_DEPTH - 1)
            begin : g_last
                assign right_w = feed;
            end
            else
            begin : g_mid
                assign right_w = cell_q[gi + 1];
            end
            ntage_cell #(
                .IDX   (gi),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk   (clk),
                .ctl   (ctl),
                .count (count_reg),
                .right (right_w),
                .feed  (feed),
                .entry (cell_q[gi])
            );
        end
    endgenerate

    assign head = cell_q[0];

    // The row is a queue: each walk cycle pops the head and pushes it back
    // (refreshed on a hit), or drops it on purge when it has aged out.
    always_comb
    begin
        fresh.id       = id_reg;
        fresh.distance = dist_reg;
        fresh.stamp    = now_reg;
        age    = now_reg - head.stamp;     // wraps mod 256
        is_hit = (func_reg == ntage_pkg::FUNC_RECEIVE) && !hit_reg && (head.id == id_reg);
        is_old = (func_reg == ntage_pkg::FUNC_PURGE) && (age > age_limit_reg);
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        steps_next   = steps_reg;
        removed_next = removed_reg;
        hit_next     = hit_reg;
        done_next    = 1'b0;
        ecount_next  = ecount_reg;
        status_next  = status_reg;
        rcount_next  = rcount_reg;
        ctl          = '0;
        feed         = is_hit ? fresh : head;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next   = S_WALK;
                    steps_next   = count_reg;
                    removed_next = '0;
                    hit_next     = 1'b0;
                end
            end
            S_WALK:
            begin
                if (steps_reg != '0)
                begin
                    ctl.rotate = 1'b1;
                    steps_next = steps_reg - 1'b1;
                    if (is_hit)
                        hit_next = 1'b1;
                    if (is_old)
                    begin
                        count_next   = count_reg - 1'b1;
                        removed_next = removed_reg + 1'b1;
                    end
                end
                else if ((func_reg == ntage_pkg::FUNC_RECEIVE) && !hit_reg
                         && (count_reg < DEPTH_C))
                begin
                    state_next = S_APPEND;
                end
                else
                begin
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                    ecount_next = 3'(count_reg);
                    rcount_next = 3'(removed_reg);
                    priority if (func_reg == ntage_pkg::FUNC_PURGE)
                        status_next = ntage_pkg::ST_PURGED;
                    else if (hit_reg)
                        status_next = ntage_pkg::ST_UPDATED;
                    else
                        status_next = ntage_pkg::ST_DROPPED;
                end
            end
            S_APPEND:
            begin
                ctl.append  = 1'b1;
                feed        = fresh;
                count_next  = count_reg + 1'b1;
                state_next  = S_IDLE;
                done_next   = 1'b1;
                ecount_next = 3'(count_reg + 1'b1);
                rcount_next = '0;
                status_next = ntage_pkg::ST_INSERTED;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            done_reg      <= 1'b0;
            age_limit_reg <= ntage_pkg::AGE_LIMIT_RESET;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
                age_limit_reg <= cfg_data;
        end
    end

    // working and payload registers
    always_ff @(posedge clk)
    begin
        steps_reg   <= steps_next;
        removed_reg <= removed_next;
        hit_reg     <= hit_next;
        ecount_reg  <= ecount_next;
        status_reg  <= status_next;
        rcount_reg  <= rcount_next;
        if (accept)
        begin
            func_reg <= func;
            id_reg   <= sender_id;
            dist_reg <= measured_distance;
            now_reg  <= now_tick;
        end
    end

    assign done          = done_reg;
    assign entry_count   = ecount_reg;
    assign status        = status_reg;
    assign removed_count = rcount_reg;

    // ---- checks ----
    `NTAGE_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= DEPTH_C, "entry count above depth")
    `NTAGE_ASSERT_NEXT(a_start_busy, accept, busy && !done, "accepted item did not occupy block")
    `NTAGE_ASSERT_NOW(a_drop_full, done && (status == ntage_pkg::ST_DROPPED),
                      count_reg == DEPTH_C, "drop reported with free slot")
    `NTAGE_ASSERT_NOW(a_removed_purge, done && (status != ntage_pkg::ST_PURGED),
                      removed_count == 3'd0, "removal reported on update")
    `NTAGE_ASSERT_NOW(a_append_room, state_reg == S_APPEND, count_reg < DEPTH_C,
                      "append into full table")

endmodule
